// File: rtl/assert_macros.svh
// Assertion macros for the rasterizer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/lr_pkg.sv
// Shared types, widths and helpers for the line rasterizer.
// No dependencies; imported by lr_setup and line_rasterizer.
package lr_pkg;

  localparam int COORD_W     = 10;
  localparam int ERR_W       = 12;
  localparam int COLOR_W     = 3;
  localparam int CANVAS_SIZE = 1024;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Request codes on the action field
  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  // Line setup handed from the setup logic to the step state
  typedef struct packed {
    coord_t cursor_x;
    coord_t cursor_y;
    err_t   error_term;
    coord_t major_delta;
    coord_t minor_delta;
    logic   x_is_major;
    logic   minor_step_down;
    logic   line_busy;
  } setup_t;

  // Inside the clip window on one axis: nonzero and below CANVAS_SIZE
  function automatic logic inside_canvas(input coord_t v);
    return (v != '0) && (int'(v) < CANVAS_SIZE);
  endfunction

endpackage

// File: rtl/line_rasterizer.sv
// Channel  | Direction | Handshake          | Payload
// in_      | request   | in_valid/in_stall  | action, endpoints, line_color
// out_     | pixel     | out_valid/out_stall| pixel_x/y, color, on_canvas, last
//
// One request is taken every cycle unless out_stall holds a pixel on out_; a step request's
// pixel reaches out_ through the input register, then the result register.
// A load request gives no pixel; a step with no line in progress is dropped.
// Rate is set by the single step update (error subtract, add and compare) per cycle.
// Synchronous active-low reset clears control and line state.
// out_stall holds the result register and, through it, the input register.
// Depends on lr_pkg, lr_setup and assert_macros.svh.
`include "assert_macros.svh"

module line_rasterizer import lr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_action,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  input  color_t in_line_color,
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t out_pixel_x,
  output coord_t out_pixel_y,
  output color_t out_pixel_color,
  output logic   out_on_canvas,
  output logic   out_last_pixel
);

  // Input register
  logic   in_valid_r;
  logic   in_action_r;
  coord_t in_start_x_r, in_start_y_r, in_end_x_r, in_end_y_r;
  color_t in_color_r;

  // Line state
  logic   line_busy_r, line_busy_nxt;
  coord_t cursor_x_r, cursor_x_nxt, cursor_y_r, cursor_y_nxt;
  err_t   error_term_r, error_term_nxt;
  coord_t major_delta_r, major_delta_nxt, minor_delta_r, minor_delta_nxt;
  coord_t pixels_left_r, pixels_left_nxt;
  logic   x_is_major_r, x_is_major_nxt, minor_step_down_r, minor_step_down_nxt;
  color_t held_color_r, held_color_nxt;

  // Result register
  logic   out_valid_r, out_valid_nxt;
  coord_t out_x_r, out_y_r;
  color_t out_color_r;
  logic   out_canvas_r, out_last_r;

  logic   advance, do_load, do_step;
  setup_t setup;
  logic signed [ERR_W:0] err_acc;
  coord_t minor_cur, minor_moved;
  logic   err_in_range;

  // Pipeline control
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign do_load  = advance && (in_action_r == ACT_LOAD);
  assign do_step  = advance && (in_action_r == ACT_STEP) && line_busy_r;

  // Hold incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action_r  <= in_action;
      in_start_x_r <= in_start_x;
      in_start_y_r <= in_start_y;
      in_end_x_r   <= in_end_x;
      in_end_y_r   <= in_end_y;
      in_color_r   <= in_line_color;
    end
  end

  lr_setup u_setup (
    .start_x (in_start_x_r),
    .start_y (in_start_y_r),
    .end_x   (in_end_x_r),
    .end_y   (in_end_y_r),
    .setup   (setup)
  );

  // Error update and minor-axis move for one pixel
  always_comb begin
    err_acc = {error_term_r[ERR_W-1], error_term_r};
    if (error_term_r > 0) begin
      err_acc = err_acc - $signed({2'b00, major_delta_r, 1'b0});
    end
    err_acc     = err_acc + $signed({2'b00, minor_delta_r, 1'b0});
    minor_cur   = x_is_major_r ? cursor_y_r : cursor_x_r;
    minor_moved = minor_step_down_r ? minor_cur - 1'b1 : minor_cur + 1'b1;
  end

  // Next line state
  always_comb begin
    line_busy_nxt       = line_busy_r;
    cursor_x_nxt        = cursor_x_r;
    cursor_y_nxt        = cursor_y_r;
    error_term_nxt      = error_term_r;
    major_delta_nxt     = major_delta_r;
    minor_delta_nxt     = minor_delta_r;
    pixels_left_nxt     = pixels_left_r;
    x_is_major_nxt      = x_is_major_r;
    minor_step_down_nxt = minor_step_down_r;
    held_color_nxt      = held_color_r;
    if (do_load) begin
      line_busy_nxt       = setup.line_busy;
      cursor_x_nxt        = setup.cursor_x;
      cursor_y_nxt        = setup.cursor_y;
      error_term_nxt      = setup.error_term;
      major_delta_nxt     = setup.major_delta;
      minor_delta_nxt     = setup.minor_delta;
      pixels_left_nxt     = setup.major_delta;
      x_is_major_nxt      = setup.x_is_major;
      minor_step_down_nxt = setup.minor_step_down;
      held_color_nxt      = in_color_r;
    end else if (do_step) begin
      error_term_nxt  = err_acc[ERR_W-1:0];
      pixels_left_nxt = pixels_left_r - 1'b1;
      line_busy_nxt   = (pixels_left_r != COORD_W'(1));
      if (x_is_major_r) begin
        cursor_x_nxt = cursor_x_r + 1'b1;
        if (error_term_r > 0) cursor_y_nxt = minor_moved;
      end else begin
        cursor_y_nxt = cursor_y_r + 1'b1;
        if (error_term_r > 0) cursor_x_nxt = minor_moved;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_busy_r       <= 1'b0;
      cursor_x_r        <= '0;
      cursor_y_r        <= '0;
      error_term_r      <= '0;
      major_delta_r     <= '0;
      minor_delta_r     <= '0;
      pixels_left_r     <= '0;
      x_is_major_r      <= 1'b0;
      minor_step_down_r <= 1'b0;
      held_color_r      <= '0;
    end else begin
      line_busy_r       <= line_busy_nxt;
      cursor_x_r        <= cursor_x_nxt;
      cursor_y_r        <= cursor_y_nxt;
      error_term_r      <= error_term_nxt;
      major_delta_r     <= major_delta_nxt;
      minor_delta_r     <= minor_delta_nxt;
      pixels_left_r     <= pixels_left_nxt;
      x_is_major_r      <= x_is_major_nxt;
      minor_step_down_r <= minor_step_down_nxt;
      held_color_r      <= held_color_nxt;
    end
  end

  // Result register: load on a step, drop once taken
  assign out_valid_nxt = advance ? do_step : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_x_r      <= cursor_x_r;
      out_y_r      <= cursor_y_r;
      out_color_r  <= held_color_r;
      out_canvas_r <= inside_canvas(cursor_x_r) && inside_canvas(cursor_y_r);
      out_last_r   <= (pixels_left_r == COORD_W'(1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_on_canvas   = out_canvas_r;
  assign out_last_pixel  = out_last_r;

  // Flag the error term inside its expected band
  assign err_in_range = (error_term_r >= -12'sd2046) && (error_term_r <= 12'sd2046);

  // Busy flag tracks the remaining pixel count
  `ASSERT_ALWAYS(a_busy_count, line_busy_r == (pixels_left_r != '0), "busy/count mismatch")
  // A stalled result blocks the input stage
  `ASSERT_IMPLIES(a_stall_hold, out_valid_r && out_stall, !advance, "advance under stall")
  // Error term stays within its documented range
  `ASSERT_ALWAYS(a_err_range, err_in_range, "error out of range")

endmodule

// File: rtl/lr_setup.sv
// Line setup: axis choice, endpoint ordering and initial error term.
// Depends on lr_pkg.
module lr_setup import lr_pkg::*; (
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output setup_t setup
);

  logic signed [COORD_W:0] dx, dy, maj_raw, mnr_raw;
  logic [COORD_W:0]        adx_w, ady_w;
  coord_t                  adx, ady, maj, mnr;
  logic                    x_major, swap;

  // Signed deltas and their magnitudes
  always_comb begin
    dx    = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy    = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    adx_w = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    ady_w = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
    adx   = adx_w[COORD_W-1:0];
    ady   = ady_w[COORD_W-1:0];
  end

  // Pick the major axis, ties go to x; swap so the major coordinate increases
  always_comb begin
    x_major = (adx >= ady);
    maj_raw = x_major ? dx : dy;
    mnr_raw = x_major ? dy : dx;
    swap    = maj_raw[COORD_W];
    maj     = x_major ? adx : ady;
    mnr     = x_major ? ady : adx;
  end

  // Build the initial state of the line
  always_comb begin
    setup.cursor_x        = swap ? end_x : start_x;
    setup.cursor_y        = swap ? end_y : start_y;
    setup.major_delta     = maj;
    setup.minor_delta     = mnr;
    setup.x_is_major      = x_major;
    setup.minor_step_down = (mnr_raw != '0) && (mnr_raw[COORD_W] ^ swap);
    setup.error_term      = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
    setup.line_busy       = (maj != '0);
  end

endmodule

// File: verif/line_rasterizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_rasterizer: a directed table and random line requests.
// It predicts pixels in a local Bresenham model, takes typed pixels from directed rows, and checks each one in order.
// Depends on lr_pkg and the line_rasterizer RTL.
module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int RAND_ITEMS   = 1850;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_PIX
  } chk_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   on_canvas;
    logic   last_pixel;
  } pixel_t;

  typedef struct {
    action_t act;
    coord_t  sx;
    coord_t  sy;
    coord_t  ex;
    coord_t  ey;
    color_t  color;
    chk_t    chk;
    pixel_t  pix;
  } stim_row_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   in_action;
  coord_t in_start_x;
  coord_t in_start_y;
  coord_t in_end_x;
  coord_t in_end_y;
  color_t in_line_color;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_on_canvas;
  logic   out_last_pixel;

  // Line state of the local model
  logic   line_on;
  coord_t cur_x;
  coord_t cur_y;
  int     err_acc;
  coord_t major_len;
  coord_t minor_len;
  coord_t steps_left;
  logic   along_x;
  logic   minor_down;
  color_t line_col;

  pixel_t    pending_pixels[$];
  stim_row_t dir_rows[$];
  int        mismatches = 0;
  int        sent_reqs = 0;
  logic      hold_off = 1'b0;
  logic      tx_calm = 1'b0;

  line_rasterizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_on_canvas   (out_on_canvas),
    .out_last_pixel  (out_last_pixel)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Idle length: mostly short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic logic within_canvas(input coord_t v);
    return (v != '0) && (int'(v) < CANVAS_SIZE);
  endfunction

  // Advance the line model by one request; return 1 when a pixel comes out
  function automatic logic rasterize_request(input action_t act, input coord_t x0,
                                             input coord_t y0, input coord_t x1,
                                             input coord_t y1, input color_t col,
                                             output pixel_t pix);
    int     dx;
    int     dy;
    int     adx;
    int     ady;
    int     mj;
    int     mn;
    coord_t t;
    pix = '0;
    if (act == ACT_LOAD) begin
      dx = int'(x1) - int'(x0);
      dy = int'(y1) - int'(y0);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      along_x = (adx >= ady);
      mj = along_x ? dx : dy;
      // order endpoints so the major coordinate increases
      if (mj < 0) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
        dx = -dx;
        dy = -dy;
      end
      mj = along_x ? dx : dy;
      mn = along_x ? dy : dx;
      minor_down = (mn < 0);
      if (mn < 0) mn = -mn;
      cur_x = x0;
      cur_y = y0;
      major_len = coord_t'(mj);
      minor_len = coord_t'(mn);
      steps_left = coord_t'(mj);
      err_acc = 2 * mn - mj;
      line_col = col;
      line_on = (mj > 0);
      return 1'b0;
    end
    // drop steps with no line in progress
    if (!line_on) return 1'b0;
    pix.x = cur_x;
    pix.y = cur_y;
    pix.color = line_col;
    pix.on_canvas = within_canvas(cur_x) && within_canvas(cur_y);
    pix.last_pixel = (steps_left == coord_t'(1));
    if (err_acc > 0) begin
      if (along_x) cur_y = minor_down ? cur_y - 1'b1 : cur_y + 1'b1;
      else cur_x = minor_down ? cur_x - 1'b1 : cur_x + 1'b1;
      err_acc -= 2 * int'(major_len);
    end
    err_acc += 2 * int'(minor_len);
    if (along_x) cur_x = cur_x + 1'b1;
    else cur_y = cur_y + 1'b1;
    steps_left = steps_left - 1'b1;
    if (steps_left == '0) line_on = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(input action_t act, input int sx, input int sy,
                                  input int ex, input int ey, input int col,
                                  input chk_t chk, input int px, input int py,
                                  input int pc, input int on, input int last);
    stim_row_t r;
    r.act = act;
    r.sx = coord_t'(sx);
    r.sy = coord_t'(sy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    r.color = color_t'(col);
    r.chk = chk;
    r.pix.x = coord_t'(px);
    r.pix.y = coord_t'(py);
    r.pix.color = color_t'(pc);
    r.pix.on_canvas = on[0];
    r.pix.last_pixel = last[0];
    dir_rows = {dir_rows, r};
  endfunction

  task automatic report(input string what, input int got, input int exp);
    if (mismatches < 40)
      $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  // Offer one request, wait for it to be taken, then book its pixel
  task automatic send_req(input action_t act, input coord_t sx, input coord_t sy,
                          input coord_t ex, input coord_t ey, input color_t col,
                          input chk_t chk, input pixel_t typed);
    int     gap;
    logic   made;
    pixel_t p;
    gap = tx_calm ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= col;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    made = rasterize_request(act, sx, sy, ex, ey, col, p);
    sent_reqs++;
    case (chk)
      CHK_PRED: if (made) pending_pixels = {pending_pixels, p};
      CHK_PIX:  pending_pixels = {pending_pixels, typed};
      default: ;
    endcase
  endtask

  // Check accepted pixels and pick the next stall
  int rx_left  = 0;
  int rx_phase = 0;
  logic rx_calm = 1'b0;
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report("pixel with none expected", out_pixel_x, -1);
      end else begin
        e = pending_pixels.pop_front();
        if (out_pixel_x !== e.x) report("pixel_x", out_pixel_x, e.x);
        if (out_pixel_y !== e.y) report("pixel_y", out_pixel_y, e.y);
        if (out_pixel_color !== e.color) report("pixel_color", out_pixel_color, e.color);
        if (out_on_canvas !== e.on_canvas) report("on_canvas", out_on_canvas, e.on_canvas);
        if (out_last_pixel !== e.last_pixel)
          report("last_pixel", out_last_pixel, e.last_pixel);
      end
    end
    rx_phase++;
    if (rx_phase % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      out_stall <= 1'b1;
      rx_left--;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else begin
      rx_left = pick_idle();
      out_stall <= (rx_left > 0);
      if (rx_left > 0) rx_left--;
    end
  end

  // Long receiver hold-off once traffic is flowing, so the input backs up
  initial begin
    wait (sent_reqs >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    pixel_t no_pix;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     span;
    int     cls;
    int     len;
    int     n;
    int     tail;
    int     target;
    int     seqs;
    no_pix = '0;
    seqs = 0;
    in_valid = 1'b0;
    in_action = ACT_LOAD;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_line_color = '0;
    line_on = 1'b0;
    cur_x = '0;
    cur_y = '0;
    err_acc = 0;
    major_len = '0;
    minor_len = '0;
    steps_left = '0;
    along_x = 1'b0;
    minor_down = 1'b0;
    line_col = '0;
    rst_n = 1'b0;

    // step while idle, short flat line, zero length
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 0, 0, 3, 0, 7, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PIX, 0, 0, 7, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PIX, 1, 0, 7, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PIX, 2, 0, 7, 0, 1);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 5, 5, 5, 5, 2, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0, 0, 0);
    // full diagonal drawn backwards: tie picks x, endpoints swap
    add_row(ACT_LOAD, 1023, 1023, 0, 0, 5, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 1023, 1023, 1023, 1023, 7, CHK_PIX, 0, 0, 5, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    // vertical line replaces the one in progress
    add_row(ACT_LOAD, 1, 1, 1, 1023, 1, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PIX, 1, 1, 1, 1, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    // anti-diagonal: x major, minor axis steps down
    add_row(ACT_LOAD, 1023, 0, 0, 1023, 6, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PIX, 0, 1023, 6, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    // steep lines, minor stepping down and up
    add_row(ACT_LOAD, 500, 10, 490, 40, 3, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 110, 620, 100, 600, 4, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PRED, 0, 0, 0, 0, 0);
    // one-pixel line
    add_row(ACT_LOAD, 7, 7, 8, 7, 0, CHK_PRED, 0, 0, 0, 0, 0);
    add_row(ACT_STEP, 0, 0, 0, 0, 0, CHK_PIX, 7, 7, 0, 1, 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i])
      send_req(dir_rows[i].act, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
               dir_rows[i].ey, dir_rows[i].color, dir_rows[i].chk, dir_rows[i].pix);

    // Random lines: mostly load plus steps, some noise
    target = sent_reqs + RAND_ITEMS;
    while (sent_reqs < target) begin
      seqs++;
      if (seqs % 48 == 0) tx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        sx = coord_t'($urandom_range(0, COORD_MAX));
        sy = coord_t'($urandom_range(0, COORD_MAX));
        cls = $urandom_range(0, 199);
        if (cls == 0) begin
          ex = coord_t'($urandom_range(0, COORD_MAX));
          ey = coord_t'($urandom_range(0, COORD_MAX));
        end else begin
          span = (cls < 20) ? 200 : 12;
          ex = clamp_coord(int'(sx) + $urandom_range(0, 2 * span) - span);
          ey = clamp_coord(int'(sy) + $urandom_range(0, 2 * span) - span);
        end
        send_req(ACT_LOAD, sx, sy, ex, ey, color_t'($urandom), CHK_PRED, no_pix);
        len = (int'(ex) > int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        n = (int'(ey) > int'(sy)) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        if (n > len) len = n;
        // run the full line, cut it short, or overrun it into idle steps
        tail = $urandom_range(0, 99);
        if (tail < 70) n = len;
        else if (tail < 85) n = $urandom_range(0, len);
        else n = len + $urandom_range(1, 2);
        repeat (n)
          send_req(ACT_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), color_t'($urandom), CHK_PRED, no_pix);
      end else begin
        send_req(action_t'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), color_t'($urandom), CHK_PRED,
                 no_pix);
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_setup.sv
rtl/line_rasterizer.sv
verif/line_rasterizer_tb.sv
